// ===== rtl/gb3_pkg.sv =====
// shared types and constants for the 3x3 rgb gaussian blur
// no dependencies; used by every module under rtl

package gb3_pkg;

    // geometry and payload widths
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int COL_W         = 12;
    localparam int ROW_W         = 16;
    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int OUT_COL_W     = 11;
    localparam int WGT_W         = 16;
    localparam int QUEUE_DEPTH   = 4;

    // register indexes on the configuration port
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_WEIGHT_CENTER = 3'd2;
    localparam logic [2:0] REG_WEIGHT_EDGE   = 3'd3;
    localparam logic [2:0] REG_WEIGHT_CORNER = 3'd4;

    // register reset values
    localparam logic [COL_W-1:0] RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [ROW_W-1:0] RST_IMAGE_HEIGHT  = 16'd480;
    localparam logic [WGT_W-1:0] RST_WEIGHT_CENTER = 16'd9684;
    localparam logic [WGT_W-1:0] RST_WEIGHT_EDGE   = 16'd7754;
    localparam logic [WGT_W-1:0] RST_WEIGHT_CORNER = 16'd6209;

    // one column of the window: three vertically adjacent pixels
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

    // classified input pixel handed from the front to the back
    typedef struct packed {
        column_t          column;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             up;
        logic             last_col;
        logic             last_row;
    } record_t;

    // result bookkeeping carried down the arithmetic pipeline
    typedef struct packed {
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 run_last;
        logic                 frame_done;
    } meta_t;

    // weights seen by the arithmetic
    typedef struct packed {
        logic [WGT_W-1:0] center;
        logic [WGT_W-1:0] edge_w;
        logic [WGT_W-1:0] corner;
    } weights_t;

endpackage

// ===== rtl/gb3_front.sv =====
// front end: pixel intake, raster counters and the three-row line store
// depends on gb3_pkg; feeds gb3_queue

module gb3_front #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH     = gb3_pkg::QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  logic [gb3_pkg::COL_W-1:0]   eff_width,
    input  logic [gb3_pkg::ROW_W-1:0]   eff_height,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [gb3_pkg::PIX_W-1:0]   s_pix,
    input  logic [$clog2(DEPTH+1)-1:0]  q_count,
    output logic                        push,
    output gb3_pkg::record_t            push_rec
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNW = $clog2(DEPTH+1);

    logic [gb3_pkg::COL_W-1:0] col_reg;
    logic [gb3_pkg::ROW_W-1:0] row_reg;
    logic [1:0]                bank_reg;

    logic [gb3_pkg::PIX_W-1:0] mem [3][MAX_WIDTH];
    logic [gb3_pkg::PIX_W-1:0] rd_reg [3];

    logic                      st_valid_reg;
    logic [gb3_pkg::PIX_W-1:0] st_pix_reg;
    logic [gb3_pkg::COL_W-1:0] st_col_reg;
    logic [gb3_pkg::ROW_W-1:0] st_row_reg;
    logic                      st_up_reg;
    logic                      st_last_col_reg;
    logic                      st_last_row_reg;
    logic [1:0]                st_top_bank_reg;
    logic [1:0]                st_mid_bank_reg;

    logic          accept;
    logic          last_col;
    logic          last_row;
    logic [AW-1:0] addr;
    logic [1:0]    mid_bank;
    logic [1:0]    top_bank;

    // room for every transaction already in flight
    assign s_ready  = ({1'b0, q_count} + {{CNW{1'b0}}, st_valid_reg}) < (CNW+1)'(DEPTH);
    assign accept   = s_valid && s_ready;
    assign last_col = (col_reg == eff_width - 1'b1);
    assign last_row = (row_reg == eff_height - 1'b1);
    assign addr     = AW'(col_reg);

    // banks holding the previous row and the one above it (row 0 lives in bank 0)
    always_comb begin
        mid_bank = (bank_reg == 2'd0) ? 2'd2 : bank_reg - 2'd1;
        if (row_reg < 16'd2) begin
            top_bank = 2'd0;
        end else begin
            top_bank = (bank_reg == 2'd0) ? 2'd1 : ((bank_reg == 2'd1) ? 2'd2 : 2'd0);
        end
    end

    // raster position
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg  <= '0;
            row_reg  <= '0;
            bank_reg <= 2'd0;
        end else if (accept) begin
            if (last_col) begin
                col_reg <= '0;
                if (last_row) begin
                    row_reg  <= '0;
                    bank_reg <= 2'd0;
                end else begin
                    row_reg  <= row_reg + 1'b1;
                    bank_reg <= (bank_reg == 2'd2) ? 2'd0 : bank_reg + 2'd1;
                end
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // line store: write the current row, read the two rows above
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[bank_reg][addr] <= s_pix;
            for (int k = 0; k < 3; k++) begin
                rd_reg[k] <= mem[k][addr];
            end
        end
    end

    // read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_pix_reg      <= s_pix;
            st_col_reg      <= col_reg;
            st_row_reg      <= row_reg;
            st_up_reg       <= (row_reg != '0);
            st_last_col_reg <= last_col;
            st_last_row_reg <= last_row;
            st_top_bank_reg <= top_bank;
            st_mid_bank_reg <= mid_bank;
        end
    end

    // on the first row the upper taps clamp to the pixel itself
    always_comb begin
        push                    = st_valid_reg;
        push_rec.column.bot     = st_pix_reg;
        push_rec.column.mid     = st_up_reg ? rd_reg[st_mid_bank_reg] : st_pix_reg;
        push_rec.column.top     = st_up_reg ? rd_reg[st_top_bank_reg] : st_pix_reg;
        push_rec.col            = st_col_reg;
        push_rec.row            = st_row_reg;
        push_rec.up             = st_up_reg;
        push_rec.last_col       = st_last_col_reg;
        push_rec.last_row       = st_last_row_reg;
    end

endmodule

// ===== rtl/gb3_queue.sv =====
// short record queue between the front and the back
// depends on gb3_pkg

module gb3_queue #(
    parameter int DEPTH = gb3_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  gb3_pkg::record_t           push_rec,
    input  logic                       pop,
    output gb3_pkg::record_t           head,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    gb3_pkg::record_t          entry_reg [DEPTH];
    logic [PW-1:0]             wr_ptr_reg;
    logic [PW-1:0]             rd_ptr_reg;
    logic [$clog2(DEPTH+1)-1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== rtl/gb3_back.sv =====
// back end: column window, result sequencing and the weighted-sum pipeline
// depends on gb3_pkg; fed by gb3_queue

module gb3_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gb3_pkg::record_t              head,
    input  logic                          q_empty,
    output logic                          pop,
    input  gb3_pkg::weights_t             weights,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gb3_pkg::CH_W-1:0]      m_out_red,
    output logic [gb3_pkg::CH_W-1:0]      m_out_green,
    output logic [gb3_pkg::CH_W-1:0]      m_out_blue,
    output logic [gb3_pkg::OUT_COL_W-1:0] m_out_col,
    output logic [gb3_pkg::ROW_W-1:0]     m_out_row,
    output logic                          m_run_last,
    output logic                          m_frame_done
);

    localparam int CW = gb3_pkg::CH_W;
    localparam int PW = gb3_pkg::PIX_W;

    gb3_pkg::column_t col_a_reg;
    gb3_pkg::column_t col_b_reg;
    logic [3:0]       done_reg;

    logic [3:0]       flags;
    logic [3:0]       pending;
    logic [3:0]       pick;
    logic [3:0]       rest;
    logic [1:0]       sel;
    logic             en;
    logic             issue;
    logic             is_last;

    gb3_pkg::column_t cl;
    gb3_pkg::column_t cc;
    gb3_pkg::column_t cr;
    logic [PW-1:0]    tap [3][3];
    gb3_pkg::meta_t   meta;

    logic             a_valid_reg;
    logic [CW-1:0]    a_cen_reg [3];
    logic [CW+1:0]    a_edg_reg [3];
    logic [CW+1:0]    a_cor_reg [3];
    gb3_pkg::meta_t   a_meta_reg;

    logic             b_valid_reg;
    logic [CW+15:0]   b_cen_reg [3];
    logic [CW+17:0]   b_edg_reg [3];
    logic [CW+17:0]   b_cor_reg [3];
    gb3_pkg::meta_t   b_meta_reg;

    logic             m_valid_reg;
    logic [CW-1:0]    m_ch_reg [3];
    gb3_pkg::meta_t   m_meta_reg;

    logic [CW+19:0]   total [3];
    logic [CW+3:0]    shifted [3];

    // whole pipeline moves unless the output transaction is stalled
    assign en = !m_valid_reg || m_ready;

    // results this record causes, in delivery order
    always_comb begin
        flags[0] = head.up && (head.col != '0);
        flags[1] = head.up && head.last_col;
        flags[2] = head.last_row && (head.col != '0);
        flags[3] = head.last_row && head.last_col;
        pending  = flags & ~done_reg;
        pick     = pending & (~pending + 4'd1);
        rest     = pending & ~pick;
        is_last  = (rest == 4'd0);
        sel      = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (pick[i]) begin
                sel = 2'(i);
            end
        end
        issue = !q_empty && en && (pending != 4'd0);
        pop   = !q_empty && en && ((pending == 4'd0) || is_last);
    end

    // sequencing state and the column window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 4'd0;
        end else if (pop) begin
            done_reg <= 4'd0;
        end else if (issue) begin
            done_reg <= done_reg | pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            col_a_reg <= col_b_reg;
            col_b_reg <= head.column;
        end
    end

    // pick the three columns and rows for this result
    always_comb begin
        if (sel == 2'd0 || sel == 2'd2) begin
            cl = (head.col == 12'd1) ? col_b_reg : col_a_reg;
            cc = col_b_reg;
        end else begin
            cl = (head.col == '0) ? head.column : col_b_reg;
            cc = head.column;
        end
        cr = head.column;
        if (sel == 2'd0 || sel == 2'd1) begin
            tap[0][0] = cl.top; tap[0][1] = cc.top; tap[0][2] = cr.top;
            tap[1][0] = cl.mid; tap[1][1] = cc.mid; tap[1][2] = cr.mid;
            tap[2][0] = cl.bot; tap[2][1] = cc.bot; tap[2][2] = cr.bot;
        end else begin
            tap[0][0] = cl.mid; tap[0][1] = cc.mid; tap[0][2] = cr.mid;
            tap[1][0] = cl.bot; tap[1][1] = cc.bot; tap[1][2] = cr.bot;
            tap[2][0] = cl.bot; tap[2][1] = cc.bot; tap[2][2] = cr.bot;
        end
        meta.col        = (sel == 2'd0 || sel == 2'd2) ?
                          gb3_pkg::OUT_COL_W'(head.col - 1'b1) : gb3_pkg::OUT_COL_W'(head.col);
        meta.row        = (sel == 2'd0 || sel == 2'd1) ? head.row - 1'b1 : head.row;
        meta.run_last   = is_last;
        meta.frame_done = (sel == 2'd3);
    end

    // stage a: per channel tap sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_meta_reg <= meta;
            for (int k = 0; k < 3; k++) begin
                a_cen_reg[k] <= tap[1][1][PW-1-CW*k -: CW];
                a_edg_reg[k] <= (CW+2)'(tap[0][1][PW-1-CW*k -: CW])
                              + (CW+2)'(tap[1][0][PW-1-CW*k -: CW])
                              + (CW+2)'(tap[1][2][PW-1-CW*k -: CW])
                              + (CW+2)'(tap[2][1][PW-1-CW*k -: CW]);
                a_cor_reg[k] <= (CW+2)'(tap[0][0][PW-1-CW*k -: CW])
                              + (CW+2)'(tap[0][2][PW-1-CW*k -: CW])
                              + (CW+2)'(tap[2][0][PW-1-CW*k -: CW])
                              + (CW+2)'(tap[2][2][PW-1-CW*k -: CW]);
            end
        end
    end

    // stage b: weight products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_meta_reg <= a_meta_reg;
            for (int k = 0; k < 3; k++) begin
                b_cen_reg[k] <= (CW+16)'(a_cen_reg[k]) * (CW+16)'(weights.center);
                b_edg_reg[k] <= (CW+18)'(a_edg_reg[k]) * (CW+18)'(weights.edge_w);
                b_cor_reg[k] <= (CW+18)'(a_cor_reg[k]) * (CW+18)'(weights.corner);
            end
        end
    end

    // stage c: add, drop the fraction, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            total[k]   = (CW+20)'(b_cen_reg[k]) + (CW+20)'(b_edg_reg[k])
                       + (CW+20)'(b_cor_reg[k]);
            shifted[k] = total[k][CW+19:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_meta_reg <= b_meta_reg;
            for (int k = 0; k < 3; k++) begin
                m_ch_reg[k] <= (shifted[k] > (CW+4)'(255)) ? {CW{1'b1}} : shifted[k][CW-1:0];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = m_ch_reg[0];
    assign m_out_green  = m_ch_reg[1];
    assign m_out_blue   = m_ch_reg[2];
    assign m_out_col    = m_meta_reg.col;
    assign m_out_row    = m_meta_reg.row;
    assign m_run_last   = m_meta_reg.run_last;
    assign m_frame_done = m_meta_reg.frame_done;

endmodule

// ===== rtl/gaussian_blur_3x3_rgb.sv =====
// top level of the 3x3 rgb gaussian blur: register file and front/queue/back
// depends on gb3_pkg, gb3_front, gb3_queue, gb3_back
//
//  channel   direction  handshake                 payload
//  s_        in         s_valid / s_ready         s_pix_red, s_pix_green, s_pix_blue
//  m_        out        m_valid / m_ready         m_out_red/green/blue, m_out_col, m_out_row,
//                                                 m_run_last, m_frame_done
//  apb       in         psel, penable, pready=1   paddr, pwdata, pwrite, prdata
//
// one pixel per cycle while each pixel causes at most one result and the output is not stalled;
// a pixel causing several results holds the back while it issues them in turn: two at the last
// column of a row, two on the last row from column 1 on, and four for the final pixel of the frame.
// after its pixel's accepting edge the first result passes the queue write, tap sums, products
// and output register; the line store read happens at the accepting edge itself.
// aresetn is synchronous; the line store is not cleared and needs no clearing pass.
// a stalled output freezes the arithmetic; the queue lets intake run until it fills.

module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH     = gb3_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gb3_pkg::CH_W-1:0]      s_pix_red,
    input  logic [gb3_pkg::CH_W-1:0]      s_pix_green,
    input  logic [gb3_pkg::CH_W-1:0]      s_pix_blue,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gb3_pkg::CH_W-1:0]      m_out_red,
    output logic [gb3_pkg::CH_W-1:0]      m_out_green,
    output logic [gb3_pkg::CH_W-1:0]      m_out_blue,
    output logic [gb3_pkg::OUT_COL_W-1:0] m_out_col,
    output logic [gb3_pkg::ROW_W-1:0]     m_out_row,
    output logic                          m_run_last,
    output logic                          m_frame_done,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [gb3_pkg::COL_W-1:0] width_reg;
    logic [gb3_pkg::ROW_W-1:0] height_reg;
    logic [gb3_pkg::WGT_W-1:0] wc_reg;
    logic [gb3_pkg::WGT_W-1:0] we_reg;
    logic [gb3_pkg::WGT_W-1:0] wd_reg;

    logic                       wr_en;
    logic [2:0]                 reg_idx;
    logic                       restart;
    logic [gb3_pkg::COL_W-1:0]  eff_width;
    logic [gb3_pkg::ROW_W-1:0]  eff_height;
    gb3_pkg::weights_t          weights;

    logic                       push;
    gb3_pkg::record_t           push_rec;
    logic                       pop;
    gb3_pkg::record_t           head;
    logic                       q_empty;
    logic [$clog2(DEPTH+1)-1:0] q_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign restart = wr_en && ((reg_idx == gb3_pkg::REG_IMAGE_WIDTH) ||
                               (reg_idx == gb3_pkg::REG_IMAGE_HEIGHT));

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= gb3_pkg::RST_IMAGE_WIDTH;
            height_reg <= gb3_pkg::RST_IMAGE_HEIGHT;
            wc_reg     <= gb3_pkg::RST_WEIGHT_CENTER;
            we_reg     <= gb3_pkg::RST_WEIGHT_EDGE;
            wd_reg     <= gb3_pkg::RST_WEIGHT_CORNER;
        end else if (wr_en) begin
            unique case (reg_idx)
                gb3_pkg::REG_IMAGE_WIDTH:   width_reg  <= pwdata[gb3_pkg::COL_W-1:0];
                gb3_pkg::REG_IMAGE_HEIGHT:  height_reg <= pwdata[gb3_pkg::ROW_W-1:0];
                gb3_pkg::REG_WEIGHT_CENTER: wc_reg     <= pwdata[gb3_pkg::WGT_W-1:0];
                gb3_pkg::REG_WEIGHT_EDGE:   we_reg     <= pwdata[gb3_pkg::WGT_W-1:0];
                gb3_pkg::REG_WEIGHT_CORNER: wd_reg     <= pwdata[gb3_pkg::WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            gb3_pkg::REG_IMAGE_WIDTH:   prdata = 32'(width_reg);
            gb3_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(height_reg);
            gb3_pkg::REG_WEIGHT_CENTER: prdata = 32'(wc_reg);
            gb3_pkg::REG_WEIGHT_EDGE:   prdata = 32'(we_reg);
            gb3_pkg::REG_WEIGHT_CORNER: prdata = 32'(wd_reg);
            default:                    prdata = 32'd0;
        endcase
    end

    // zero width acts as one, oversize width as the line store size; zero height as one
    always_comb begin
        if (width_reg == '0) begin
            eff_width = gb3_pkg::COL_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_width = gb3_pkg::COL_W'(MAX_WIDTH);
        end else begin
            eff_width = width_reg;
        end
        eff_height     = (height_reg == '0) ? gb3_pkg::ROW_W'(1) : height_reg;
        weights.center = wc_reg;
        weights.edge_w = we_reg;
        weights.corner = wd_reg;
    end

    gb3_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .DEPTH     (DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pix      ({s_pix_red, s_pix_green, s_pix_blue}),
        .q_count    (q_count),
        .push       (push),
        .push_rec   (push_rec)
    );

    gb3_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .count    (q_count)
    );

    gb3_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .weights      (weights),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_run_last   (m_run_last),
        .m_frame_done (m_frame_done)
    );

    // queue never overflows
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(q_count) <= DEPTH))
        else $error("record queue over its depth");

    // a full queue blocks intake
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(q_count) == DEPTH) |-> !s_ready)
        else $error("pixel taken with the queue full");

    // the frame's final result closes its pixel's run and sits on the bottom row
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (m_run_last && (m_out_row == eff_height - 1'b1)))
        else $error("frame end flag on a wrong result");

endmodule
